// File: rtl/assert_macros.svh
// assertion helpers shared by the point range and view cone check
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// implication after a fixed number of cycles, disabled while in reset
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
        else $error("delayed implication check failed");

`endif

// File: rtl/prvc_pkg.sv
// shared types and constants for the point range and view cone check
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prvc_pkg;

    // field widths
    localparam int COORD_BITS   = 24;
    localparam int INDEX_BITS   = 16;
    localparam int DIR_BITS     = 16;
    localparam int COS_BITS     = 16;
    localparam int REG_IDX_BITS = 3;

    // datapath widths
    localparam int DIFF_W  = COORD_BITS + 1;          // viewer minus point
    localparam int SQ_W    = 2 * COORD_BITS;          // one squared component
    localparam int S2_W    = SQ_W + 2;                // sum of three squares
    localparam int PROD_W  = DIFF_W + DIR_BITS;       // one dot product term
    localparam int DOT_W   = PROD_W + 2;              // sum of three terms
    localparam int DM_W    = COORD_BITS + DIR_BITS + 1;  // magnitude of dot
    localparam int C2_W    = 2 * COS_BITS - 1;        // squared cosine bound
    localparam int WIDE_W  = 2 * DM_W;                // squared dot / scaled s2

    // split points for the wide squares
    localparam int DM_LO_W = (DM_W + 1) / 2;
    localparam int DM_HI_W = DM_W - DM_LO_W;
    localparam int S2_LO_W = S2_W / 2;
    localparam int S2_HI_W = S2_W - S2_LO_W;

    // configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_VIEW_POS_X    = 3'd0,
        REG_VIEW_POS_Y    = 3'd1,
        REG_VIEW_POS_Z    = 3'd2,
        REG_MIN_RANGE     = 3'd3,
        REG_MAX_RANGE     = 3'd4,
        REG_MIN_VIEW_COS  = 3'd5,
        REG_VIEW_FILTER   = 3'd6
    } t_reg_idx;

    // input item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic signed [DIR_BITS-1:0]   dir_x;
        logic signed [DIR_BITS-1:0]   dir_y;
        logic signed [DIR_BITS-1:0]   dir_z;
        logic                         dir_present;
        logic [INDEX_BITS-1:0]        point_index;
        logic                         last_point;
    } t_point_in;

    // result item
    typedef struct packed {
        logic [INDEX_BITS-1:0] index_out;
        logic                  visible;
        logic                  last_out;
    } t_result;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [COORD_BITS-1:0] view_x;
        logic signed [COORD_BITS-1:0] view_y;
        logic signed [COORD_BITS-1:0] view_z;
        logic [SQ_W-1:0]              min_sq;
        logic [SQ_W-1:0]              max_sq;
        logic [C2_W-1:0]              cos_sq;
        logic                         cos_neg;
        logic                         filter_on;
    } t_cfg;

    // side data that travels with each point
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  last;
        logic                  cone_en;
    } t_tag;

    // geometry stage results handed to the cone stages
    typedef struct packed {
        logic [S2_W-1:0]         s2;
        logic signed [DOT_W-1:0] dot;
        t_tag                    tag;
    } t_geom;

endpackage

`default_nettype wire

// File: rtl/prvc_cfg_regs.sv
// configuration registers with registered squared bounds
// depends on prvc_pkg
`timescale 1ns / 1ps
`default_nettype none

module prvc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [prvc_pkg::REG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [prvc_pkg::COORD_BITS-1:0]  i_cfg_data,
    output prvc_pkg::t_cfg                        o_cfg
);

    logic signed [prvc_pkg::COORD_BITS-1:0] r_view_x, r_view_y, r_view_z;
    logic [prvc_pkg::COORD_BITS-1:0]        r_min_range, r_max_range;
    logic signed [prvc_pkg::COS_BITS-1:0]   r_min_cos;
    logic                                   r_filter_on;
    logic [prvc_pkg::SQ_W-1:0]              r_min_sq, r_max_sq;
    logic [prvc_pkg::C2_W-1:0]              r_cos_sq;
    logic signed [2*prvc_pkg::COS_BITS-1:0] n_cos_sq_full;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x    <= '0;
            r_view_y    <= '0;
            r_view_z    <= '0;
            r_min_range <= '0;
            r_max_range <= '1;
            r_min_cos   <= '0;
            r_filter_on <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prvc_pkg::REG_VIEW_POS_X:   r_view_x    <= $signed(i_cfg_data);
                prvc_pkg::REG_VIEW_POS_Y:   r_view_y    <= $signed(i_cfg_data);
                prvc_pkg::REG_VIEW_POS_Z:   r_view_z    <= $signed(i_cfg_data);
                prvc_pkg::REG_MIN_RANGE:    r_min_range <= i_cfg_data;
                prvc_pkg::REG_MAX_RANGE:    r_max_range <= i_cfg_data;
                prvc_pkg::REG_MIN_VIEW_COS: r_min_cos   <= $signed(i_cfg_data[prvc_pkg::COS_BITS-1:0]);
                prvc_pkg::REG_VIEW_FILTER:  r_filter_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // squared cosine bound, always non-negative and below 2**30 + 1
    always_comb begin
        n_cos_sq_full = r_min_cos * r_min_cos;
    end

    // squared bounds follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_min_sq <= r_min_range * r_min_range;
        r_max_sq <= r_max_range * r_max_range;
        r_cos_sq <= n_cos_sq_full[prvc_pkg::C2_W-1:0];
    end

    assign o_cfg.view_x    = r_view_x;
    assign o_cfg.view_y    = r_view_y;
    assign o_cfg.view_z    = r_view_z;
    assign o_cfg.min_sq    = r_min_sq;
    assign o_cfg.max_sq    = r_max_sq;
    assign o_cfg.cos_sq    = r_cos_sq;
    assign o_cfg.cos_neg   = r_min_cos[prvc_pkg::COS_BITS-1];
    assign o_cfg.filter_on = r_filter_on;

endmodule

`default_nettype wire

// File: rtl/prvc_geom.sv
// geometry stages: offset to viewer, squared components, dot products, sums
// depends on prvc_pkg
`timescale 1ns / 1ps
`default_nettype none

module prvc_geom (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire prvc_pkg::t_point_in i_item,
    input  wire prvc_pkg::t_cfg      i_cfg,
    output logic                     o_valid,
    output prvc_pkg::t_geom          o_geom
);

    localparam int CB = prvc_pkg::COORD_BITS;

    logic                                 r_s1_valid, r_s2_valid, r_s3_valid;
    logic signed [prvc_pkg::DIFF_W-1:0]   r_s1_d   [3];
    logic signed [prvc_pkg::DIR_BITS-1:0] r_s1_dir [3];
    prvc_pkg::t_tag                       r_s1_tag, r_s2_tag, r_s3_tag;
    logic [prvc_pkg::SQ_W-1:0]            r_s2_sq  [3];
    logic signed [prvc_pkg::PROD_W-1:0]   r_s2_pr  [3];
    logic [prvc_pkg::S2_W-1:0]            r_s3_s2;
    logic signed [prvc_pkg::DOT_W-1:0]    r_s3_dot;

    logic signed [CB-1:0]                 w_view [3];
    logic signed [CB-1:0]                 w_pt   [3];
    logic signed [prvc_pkg::DIFF_W-1:0]   n_d    [3];
    logic signed [2*prvc_pkg::DIFF_W-1:0] n_sq_full [3];
    logic signed [prvc_pkg::PROD_W-1:0]   n_pr   [3];

    assign w_view[0] = i_cfg.view_x;
    assign w_view[1] = i_cfg.view_y;
    assign w_view[2] = i_cfg.view_z;
    assign w_pt[0]   = i_item.point_x;
    assign w_pt[1]   = i_item.point_y;
    assign w_pt[2]   = i_item.point_z;

    // stage 1: viewer minus point, one extra bit
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d[k] = $signed({w_view[k][CB-1], w_view[k]}) - $signed({w_pt[k][CB-1], w_pt[k]});
        end
    end

    // stage 2: squares and direction products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sq_full[k] = r_s1_d[k] * r_s1_d[k];
            n_pr[k]      = r_s1_d[k] * r_s1_dir[k];
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s1_d           <= n_d;
        r_s1_dir[0]      <= i_item.dir_x;
        r_s1_dir[1]      <= i_item.dir_y;
        r_s1_dir[2]      <= i_item.dir_z;
        r_s1_tag.index   <= i_item.point_index;
        r_s1_tag.last    <= i_item.last_point;
        r_s1_tag.cone_en <= i_item.dir_present & i_cfg.filter_on;

        for (int k = 0; k < 3; k++) begin
            r_s2_sq[k] <= n_sq_full[k][prvc_pkg::SQ_W-1:0];
        end
        r_s2_pr  <= n_pr;
        r_s2_tag <= r_s1_tag;

        // stage 3: sums of three
        r_s3_s2  <= prvc_pkg::S2_W'(r_s2_sq[0]) + prvc_pkg::S2_W'(r_s2_sq[1])
                  + prvc_pkg::S2_W'(r_s2_sq[2]);
        r_s3_dot <= prvc_pkg::DOT_W'(r_s2_pr[0]) + prvc_pkg::DOT_W'(r_s2_pr[1])
                  + prvc_pkg::DOT_W'(r_s2_pr[2]);
        r_s3_tag <= r_s2_tag;
    end

    assign o_valid     = r_s3_valid;
    assign o_geom.s2   = r_s3_s2;
    assign o_geom.dot  = r_s3_dot;
    assign o_geom.tag  = r_s3_tag;

endmodule

`default_nettype wire

// File: rtl/prvc_cone.sv
// range compare and cone test on squared terms, result register
// depends on prvc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module prvc_cone (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire prvc_pkg::t_geom i_geom,
    input  wire prvc_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    output prvc_pkg::t_result    o_result
);

    localparam int DLO = prvc_pkg::DM_LO_W;
    localparam int DHI = prvc_pkg::DM_HI_W;
    localparam int SLO = prvc_pkg::S2_LO_W;
    localparam int SHI = prvc_pkg::S2_HI_W;
    localparam int WW  = prvc_pkg::WIDE_W;

    logic                       r_s4_valid, r_s5_valid, r_s6_valid, r_s7_valid;
    prvc_pkg::t_tag             r_s4_tag, r_s5_tag, r_s6_tag;
    logic                       r_s4_range_ok, r_s5_range_ok, r_s6_range_ok;
    logic                       r_s4_dot_pos, r_s5_dot_pos, r_s6_dot_pos;
    logic                       r_s4_dot_nneg, r_s5_dot_nneg, r_s6_dot_nneg;
    logic [prvc_pkg::DM_W-1:0]  r_s4_dm;
    logic [prvc_pkg::S2_W-1:0]  r_s4_s2;
    logic [2*DHI-1:0]           r_s5_hh;
    logic [DHI+DLO-1:0]         r_s5_hl;
    logic [2*DLO-1:0]           r_s5_ll;
    logic [SHI+prvc_pkg::C2_W-1:0] r_s5_rh;
    logic [SLO+prvc_pkg::C2_W-1:0] r_s5_rl;
    logic [WW-1:0]              r_s6_lhs, r_s6_rhs;
    prvc_pkg::t_result          r_s7_result;

    logic [prvc_pkg::DOT_W-1:0] n_dm_full;
    logic                       n_cone_ok;

    // magnitude of the dot product
    always_comb begin
        n_dm_full = i_geom.dot[prvc_pkg::DOT_W-1] ? (~i_geom.dot + 1'b1) : i_geom.dot;
    end

    // final cone decision: dot > cos * |d| without the root
    always_comb begin
        if (i_cfg.cos_neg) begin
            n_cone_ok = r_s6_dot_nneg || (r_s6_lhs < r_s6_rhs);
        end else begin
            n_cone_ok = r_s6_dot_pos && (r_s6_rhs < r_s6_lhs);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else begin
            r_s4_valid <= i_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 4: range window, dot sign and magnitude
        r_s4_range_ok <= (prvc_pkg::S2_W'(i_cfg.min_sq) < i_geom.s2)
                      && (i_geom.s2 < prvc_pkg::S2_W'(i_cfg.max_sq));
        r_s4_dot_nneg <= !i_geom.dot[prvc_pkg::DOT_W-1];
        r_s4_dot_pos  <= !i_geom.dot[prvc_pkg::DOT_W-1] && (i_geom.dot != '0);
        r_s4_dm       <= n_dm_full[prvc_pkg::DM_W-1:0];
        r_s4_s2       <= i_geom.s2;
        r_s4_tag      <= i_geom.tag;

        // stage 5: partial products of dot squared and s2 times cos squared
        r_s5_hh       <= r_s4_dm[prvc_pkg::DM_W-1:DLO] * r_s4_dm[prvc_pkg::DM_W-1:DLO];
        r_s5_hl       <= r_s4_dm[prvc_pkg::DM_W-1:DLO] * r_s4_dm[DLO-1:0];
        r_s5_ll       <= r_s4_dm[DLO-1:0] * r_s4_dm[DLO-1:0];
        r_s5_rh       <= r_s4_s2[prvc_pkg::S2_W-1:SLO] * i_cfg.cos_sq;
        r_s5_rl       <= r_s4_s2[SLO-1:0] * i_cfg.cos_sq;
        r_s5_range_ok <= r_s4_range_ok;
        r_s5_dot_pos  <= r_s4_dot_pos;
        r_s5_dot_nneg <= r_s4_dot_nneg;
        r_s5_tag      <= r_s4_tag;

        // stage 6: recombine the partial products
        r_s6_lhs      <= (WW'(r_s5_hh) << (2 * DLO)) + (WW'(r_s5_hl) << (DLO + 1))
                       + WW'(r_s5_ll);
        r_s6_rhs      <= (WW'(r_s5_rh) << SLO) + WW'(r_s5_rl);
        r_s6_range_ok <= r_s5_range_ok;
        r_s6_dot_pos  <= r_s5_dot_pos;
        r_s6_dot_nneg <= r_s5_dot_nneg;
        r_s6_tag      <= r_s5_tag;

        // stage 7: result register
        r_s7_result.index_out <= r_s6_tag.index;
        r_s7_result.last_out  <= r_s6_tag.last;
        r_s7_result.visible   <= r_s6_range_ok && (!r_s6_tag.cone_en || n_cone_ok);
    end

    assign o_valid  = r_s7_valid;
    assign o_result = r_s7_result;

    // a visible result must have passed the range window three stages back
    `ASSERT_IMPL(a_visible_in_range, i_clk, i_rst_n, r_s7_valid && r_s7_result.visible,
                 $past(r_s4_range_ok, 3))
    // every transfer in passes stages 4, 5 and 6 and then leaves the result register
    `ASSERT_DELAY(a_valid_flows, i_clk, i_rst_n, i_valid, 4, o_valid)
    // a positive dot product is never flagged negative
    `ASSERT_IMPL(a_dot_sign_kept, i_clk, i_rst_n, r_s4_valid && r_s4_dot_pos, r_s4_dot_nneg)

endmodule

`default_nettype wire

// File: rtl/point_range_and_view_cone_check.sv
// top level of the point range and view cone check
// depends on prvc_pkg, prvc_cfg_regs, prvc_geom, prvc_cone, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// One point is taken in every clock cycle: busy is never raised, so a point
// transfers at every edge where start is high. Its result leaves on o_result
// with o_result_valid high for a single cycle, in input order, and must be
// captured then since there is no way to hold it. The pipeline stages are:
// offset, squares and dot terms, sums, range compare, split partial products of
// the 82-bit squared dot and scaled distance, recombination, and the final
// compare. Configuration writes take effect at the write edge; the squared
// range and cosine bounds follow in the cycle after, so a point may be started
// from the cycle after the last write.
module point_range_and_view_cone_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire prvc_pkg::t_point_in               i_item,
    output logic                                   o_result_valid,
    output prvc_pkg::t_result                      o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [prvc_pkg::REG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [prvc_pkg::COORD_BITS-1:0]   i_cfg_data
);

    prvc_pkg::t_cfg  w_cfg;
    prvc_pkg::t_geom w_geom;
    logic            w_geom_valid;
    logic            w_accept;

    // the pipeline never stalls
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // configuration registers
    prvc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // geometry stages
    prvc_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .i_cfg   (w_cfg),
        .o_valid (w_geom_valid),
        .o_geom  (w_geom)
    );

    // range and cone stages
    prvc_cone u_cone (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_geom_valid),
        .i_geom   (w_geom),
        .i_cfg    (w_cfg),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

    // every transfer in gives a result after the geometry and cone stages
    `ASSERT_DELAY(a_result_follows, i_clk, i_rst_n, w_accept, 7, o_result_valid)
    // the result carries the index of the point it belongs to
    `ASSERT_IMPL(a_index_kept, i_clk, i_rst_n, o_result_valid,
                 o_result.index_out == $past(i_item.point_index, 7))
    // batch end marker travels with its point
    `ASSERT_IMPL(a_last_kept, i_clk, i_rst_n, o_result_valid,
                 o_result.last_out == $past(i_item.last_point, 7))

endmodule

`default_nettype wire

// File: tb/point_visibility_checker.sv
// result checker for the point range and view cone check: predicts visibility per point
// depends on prvc_pkg; watches the point, result and register write ports of the block
`timescale 1ns / 1ps

module point_visibility_checker (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic                                        i_busy,
    input  prvc_pkg::t_point_in                         i_item,
    input  logic                                        i_result_valid,
    input  prvc_pkg::t_result                           i_result,
    input  logic                                        i_cfg_we,
    input  logic [prvc_pkg::REG_IDX_BITS-1:0]           i_cfg_idx,
    input  logic [prvc_pkg::COORD_BITS-1:0]             i_cfg_data,
    output int                                          o_fail_count,
    output int                                          o_pending
);

    // own copy of the register file
    logic signed [prvc_pkg::COORD_BITS-1:0] view_x = '0;
    logic signed [prvc_pkg::COORD_BITS-1:0] view_y = '0;
    logic signed [prvc_pkg::COORD_BITS-1:0] view_z = '0;
    logic [prvc_pkg::COORD_BITS-1:0]        range_lo = '0;
    logic [prvc_pkg::COORD_BITS-1:0]        range_hi = '1;
    logic signed [prvc_pkg::COS_BITS-1:0]   cos_floor = '0;
    logic                                   cone_on = 1'b0;

    // predicted results in transfer order
    prvc_pkg::t_result results_due[$];
    prvc_pkg::t_result want;
    int                fails = 0;

    function automatic logic [127:0] mag_wide(input longint v);
        logic [63:0] u;
        u = (v < 0) ? -v : v;
        return {64'd0, u};
    endfunction

    // exact visibility test on squared terms, no square root
    function automatic logic visible_from_view(input prvc_pkg::t_point_in p);
        longint       dx, dy, dz, dot, c;
        logic [127:0] s2, lo_sq, hi_sq, bound, cm, dm, lhs, rhs;
        logic         vis;
        dx = longint'($signed(view_x)) - longint'($signed(p.point_x));
        dy = longint'($signed(view_y)) - longint'($signed(p.point_y));
        dz = longint'($signed(view_z)) - longint'($signed(p.point_z));
        s2 = mag_wide(dx) * mag_wide(dx) + mag_wide(dy) * mag_wide(dy)
           + mag_wide(dz) * mag_wide(dz);
        bound = {104'd0, range_lo};
        lo_sq = bound * bound;
        bound = {104'd0, range_hi};
        hi_sq = bound * bound;
        vis = (lo_sq < s2) && (s2 < hi_sq);
        // cone test: dot > cos * |d|, compared as squares with sign handling
        if (vis && cone_on && p.dir_present) begin
            dot = dx * longint'($signed(p.dir_x)) + dy * longint'($signed(p.dir_y))
                + dz * longint'($signed(p.dir_z));
            c   = longint'(cos_floor);
            cm  = mag_wide(c);
            rhs = s2 * (cm * cm);
            dm  = mag_wide(dot);
            lhs = dm * dm;
            if (c >= 0) begin
                vis = (dot > 0) && (rhs < lhs);
            end else begin
                vis = (dot >= 0) || (lhs < rhs);
            end
        end
        return vis;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            view_x    = '0;
            view_y    = '0;
            view_z    = '0;
            range_lo  = '0;
            range_hi  = '1;
            cos_floor = '0;
            cone_on   = 1'b0;
            results_due.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_result_valid) begin
                if (results_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, %s %0d visible %0d last %0d",
                             $time, "actual index", i_result.index_out, i_result.visible,
                             i_result.last_out);
                end else begin
                    want = results_due.pop_front();
                    check_field("index_out", want.index_out, i_result.index_out);
                    check_field("visible", want.visible, i_result.visible);
                    check_field("last_out", want.last_out, i_result.last_out);
                end
            end
            // register writes, unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prvc_pkg::REG_VIEW_POS_X:   view_x    = i_cfg_data;
                    prvc_pkg::REG_VIEW_POS_Y:   view_y    = i_cfg_data;
                    prvc_pkg::REG_VIEW_POS_Z:   view_z    = i_cfg_data;
                    prvc_pkg::REG_MIN_RANGE:    range_lo  = i_cfg_data;
                    prvc_pkg::REG_MAX_RANGE:    range_hi  = i_cfg_data;
                    prvc_pkg::REG_MIN_VIEW_COS: cos_floor = i_cfg_data[prvc_pkg::COS_BITS-1:0];
                    prvc_pkg::REG_VIEW_FILTER:  cone_on   = i_cfg_data[0];
                    default: ;
                endcase
            end
            // point transfer
            if (i_start && !i_busy) begin
                want.index_out = i_item.point_index;
                want.visible   = visible_from_view(i_item);
                want.last_out  = i_item.last_point;
                results_due.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// File: tb/point_range_and_view_cone_check_test.sv
// top of the point range and view cone check test: stimulus, pacing and verdict
// depends on prvc_pkg, point_range_and_view_cone_check and point_visibility_checker
`timescale 1ns / 1ps

module point_range_and_view_cone_check_test;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 12;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_POINTS   = 56;
    localparam logic [prvc_pkg::REG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    prvc_pkg::t_point_in               i_item = '0;
    logic                              o_result_valid;
    prvc_pkg::t_result                 o_result;
    logic                              i_cfg_we = 1'b0;
    logic [prvc_pkg::REG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [prvc_pkg::COORD_BITS-1:0]   i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    int burst_left = 0;

    // viewer position as last written, used to aim points
    logic [prvc_pkg::COORD_BITS-1:0] aim_x = '0;
    logic [prvc_pkg::COORD_BITS-1:0] aim_y = '0;
    logic [prvc_pkg::COORD_BITS-1:0] aim_z = '0;
    logic [prvc_pkg::INDEX_BITS-1:0] point_seq = 16'hFFFC;

    point_range_and_view_cone_check dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    point_visibility_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one register write per edge; the enable stays high across a run of writes
    task automatic write_reg(input logic [prvc_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [prvc_pkg::COORD_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            prvc_pkg::REG_VIEW_POS_X: aim_x = data;
            prvc_pkg::REG_VIEW_POS_Y: aim_y = data;
            prvc_pkg::REG_VIEW_POS_Z: aim_z = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    // hold the point until the block takes it
    task automatic send_point(input prvc_pkg::t_point_in p);
        i_item <= p;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // bursts of random length with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every predicted result has arrived, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_fixed(input logic [prvc_pkg::COORD_BITS-1:0] x,
                              input logic [prvc_pkg::COORD_BITS-1:0] y,
                              input logic [prvc_pkg::COORD_BITS-1:0] z,
                              input logic [prvc_pkg::DIR_BITS-1:0] ux,
                              input logic [prvc_pkg::DIR_BITS-1:0] uy,
                              input logic [prvc_pkg::DIR_BITS-1:0] uz,
                              input logic present);
        prvc_pkg::t_point_in p;
        p.point_x     = x;
        p.point_y     = y;
        p.point_z     = z;
        p.dir_x       = ux;
        p.dir_y       = uy;
        p.dir_z       = uz;
        p.dir_present = present;
        p.point_index = point_seq;
        p.last_point  = (point_seq[1:0] == 2'b11);
        point_seq++;
        send_point(p);
        pace();
    endtask

    // random value of random magnitude, all 24 bits at the top scale
    function automatic logic [prvc_pkg::COORD_BITS-1:0] scaled_rand();
        int          k;
        logic [31:0] m;
        logic [31:0] r;
        k = $urandom_range(0, prvc_pkg::COORD_BITS);
        m = (32'd1 << k) - 32'd1;
        r = $urandom() & m;
        return r[prvc_pkg::COORD_BITS-1:0];
    endfunction

    function automatic logic [prvc_pkg::COORD_BITS-1:0] near(
        input logic [prvc_pkg::COORD_BITS-1:0] base);
        logic [prvc_pkg::COORD_BITS-1:0] off;
        off = scaled_rand();
        if ($urandom_range(0, 1) == 1) off = -off;
        return base + off;
    endfunction

    function automatic logic [prvc_pkg::COORD_BITS-1:0] pick_view();
        case ($urandom_range(0, 5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            default: return near('0);
        endcase
    endfunction

    function automatic logic [prvc_pkg::DIR_BITS-1:0] pick_dir();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return raw[prvc_pkg::DIR_BITS-1:0];
        endcase
    endfunction

    // mostly points around the viewer, some anywhere
    function automatic prvc_pkg::t_point_in random_point();
        prvc_pkg::t_point_in p;
        logic [31:0]         raw;
        if ($urandom_range(0, 4) == 0) begin
            raw       = $urandom();
            p.point_x = raw[prvc_pkg::COORD_BITS-1:0];
            raw       = $urandom();
            p.point_y = raw[prvc_pkg::COORD_BITS-1:0];
            raw       = $urandom();
            p.point_z = raw[prvc_pkg::COORD_BITS-1:0];
        end else begin
            p.point_x = near(aim_x);
            p.point_y = near(aim_y);
            p.point_z = near(aim_z);
        end
        p.dir_x       = pick_dir();
        p.dir_y       = pick_dir();
        p.dir_z       = pick_dir();
        p.dir_present = ($urandom_range(0, 3) != 0);
        p.point_index = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : point_seq;
        p.last_point  = ($urandom_range(0, 7) == 0);
        point_seq++;
        return p;
    endfunction

    task automatic random_config();
        logic [prvc_pkg::COORD_BITS-1:0] lo;
        logic [prvc_pkg::COORD_BITS-1:0] hi;
        logic [prvc_pkg::COS_BITS-1:0]   cos_val;
        logic [7:0]                      pad8;
        logic [22:0]                     pad23;
        logic [31:0]                     raw;
        write_reg(prvc_pkg::REG_VIEW_POS_X, pick_view());
        write_reg(prvc_pkg::REG_VIEW_POS_Y, pick_view());
        write_reg(prvc_pkg::REG_VIEW_POS_Z, pick_view());
        case ($urandom_range(0, 5))
            0:       lo = '0;
            1:       lo = '1;
            default: lo = scaled_rand();
        endcase
        case ($urandom_range(0, 5))
            0:       hi = '1;
            1:       hi = '0;
            2:       hi = lo;
            default: hi = lo + scaled_rand();
        endcase
        write_reg(prvc_pkg::REG_MIN_RANGE, lo);
        write_reg(prvc_pkg::REG_MAX_RANGE, hi);
        raw = $urandom();
        case ($urandom_range(0, 5))
            0:       cos_val = 16'h8000;
            1:       cos_val = 16'h7FFF;
            2:       cos_val = 16'h0000;
            default: cos_val = raw[prvc_pkg::COS_BITS-1:0];
        endcase
        raw   = $urandom();
        pad8  = raw[7:0];
        raw   = $urandom();
        pad23 = raw[22:0];
        write_reg(prvc_pkg::REG_MIN_VIEW_COS, {pad8, cos_val});
        write_reg(prvc_pkg::REG_VIEW_FILTER, {pad23, 1'($urandom_range(0, 3) != 0)});
        raw = $urandom();
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, raw[prvc_pkg::COORD_BITS-1:0]);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: range only, viewer at the origin
        send_fixed(24'h000000, 24'h000000, 24'h000000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
        send_fixed(24'h000001, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_fixed(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_fixed(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_fixed(24'h800000, 24'h000000, 24'h000000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
        drain();

        // viewer in a far corner, widest cone
        write_reg(prvc_pkg::REG_VIEW_POS_X, 24'h7FFFFF);
        write_reg(prvc_pkg::REG_VIEW_POS_Y, 24'h800000);
        write_reg(prvc_pkg::REG_VIEW_POS_Z, 24'h7FFFFF);
        write_reg(prvc_pkg::REG_MIN_RANGE, 24'h000000);
        write_reg(prvc_pkg::REG_MAX_RANGE, 24'hFFFFFF);
        write_reg(prvc_pkg::REG_MIN_VIEW_COS, 24'h008000);
        write_reg(prvc_pkg::REG_VIEW_FILTER, 24'h000001);
        end_writes();
        // largest distance, out of range
        send_fixed(24'h800000, 24'h7FFFFF, 24'h800000, 16'h1234, 16'h0000, 16'h0000, 1'b1);
        send_fixed(24'h7FF001, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
        // pointing away exactly at the cone edge
        send_fixed(24'h7FF001, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b1);
        send_fixed(24'h7FF001, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0);
        // direction longer than unit
        send_fixed(24'h7FF001, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        // point sitting on the viewer
        send_fixed(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
        drain();

        // narrowest cone around the origin; a write to an unknown index in between
        write_reg(prvc_pkg::REG_VIEW_POS_X, 24'h000000);
        write_reg(prvc_pkg::REG_VIEW_POS_Y, 24'h000000);
        write_reg(prvc_pkg::REG_VIEW_POS_Z, 24'h000000);
        write_reg(REG_UNMAPPED, 24'hFFFFFF);
        write_reg(prvc_pkg::REG_MIN_VIEW_COS, 24'hA57FFF);
        end_writes();
        send_fixed(24'hFFF000, 24'h000000, 24'h000000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
        send_fixed(24'hFFF000, 24'hFFF000, 24'h000000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
        send_fixed(24'hFFF000, 24'h000000, 24'h000000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
        send_fixed(24'hFFF000, 24'h000000, 24'h000000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
        drain();

        // empty shell: lower bound equal to upper bound
        write_reg(prvc_pkg::REG_MIN_RANGE, 24'h010000);
        write_reg(prvc_pkg::REG_MAX_RANGE, 24'h010000);
        end_writes();
        send_fixed(24'h008000, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_fixed(24'h010000, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_fixed(24'h018000, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        drain();

        // inverted bounds at the extremes, filter off through the low bit only
        write_reg(prvc_pkg::REG_MIN_RANGE, 24'hFFFFFF);
        write_reg(prvc_pkg::REG_MAX_RANGE, 24'h000000);
        write_reg(prvc_pkg::REG_VIEW_FILTER, 24'hFFFFFE);
        end_writes();
        send_fixed(24'h000001, 24'h000000, 24'h000000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1);
        send_fixed(24'h800000, 24'h800000, 24'h800000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        drain();

        // random settings, each followed by a stream of points
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_config();
            end_writes();
            for (int n = 0; n < PHASE_POINTS; n++) begin
                send_point(random_point());
                pace();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
